// ===== hw/rtl/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 16;
  localparam int ADDR_W        = $clog2(SYMBOL_COUNT);
  localparam int CODE_W        = 16;
  localparam int LEN_W         = 5;
  localparam int ENTRY_W       = CODE_W + LEN_W;
  localparam int WIN_W         = 8 + CODE_W;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } pack_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } entry_t;

endpackage

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// Top level of the Huffman code bit packer: code table, bit accumulator, byte queue.
//
// Huffman encoder back end. A load word (operation 0) writes one code-table
// entry; lengths above 16 are stored as 16. An encode word (operation 1) looks
// up the byte's entry and appends its code bits, most significant first, to a
// byte accumulator; every completed byte leaves on the pack channel, first code
// bit in bit 7. A flush word (operation 2) sends out a partly filled byte,
// zero padded, if bits are pending; operation 3 does nothing. The last flag
// marks the final byte produced by one input word. Encoding an entry that was
// never loaded gives undefined bytes. Timing: an input word is taken every
// cycle while the output queue has room for two bytes; the table is one
// single-port RAM with a registered read, so a word's first byte is registered
// in the table read data and then in the output queue before it is offered on
// the pack channel. The output side moves one byte per cycle while pack_ready
// is high, so a stream that averages more than one byte per word is paced by
// the consumer. No clearing pass is needed after reset.
module huffman_code_bit_packer
  import hcbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  pack_valid,
  input  logic  pack_ready,
  output pack_t pack
);

  // ---------------------------------------------------------------- stage 0
  logic         accept;
  logic         in_range;
  logic [LEN_W-1:0] len_sat;
  entry_t       wr_entry;
  entry_t       rd_entry;
  logic         ram_we;
  logic         ram_re;

  assign accept   = item_valid && item_ready;
  assign in_range = int'(item.symbol) < SYMBOL_COUNT;
  assign len_sat  = (int'(item.code_length) > MAX_CODE_BITS) ?
                    LEN_W'(MAX_CODE_BITS) : item.code_length;
  assign wr_entry = '{code: item.code_bits, length: len_sat};
  assign ram_we   = accept && (item.operation == OP_LOAD) && in_range;
  assign ram_re   = accept && (item.operation == OP_ENCODE) && in_range;

  // Code table; read data holds while stage 1 is stalled, as no read is issued.
  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (item.symbol[ADDR_W-1:0]),
    .wdata(wr_entry),
    .rdata(rd_entry)
  );

  // ---------------------------------------------------------------- stage 1
  logic       s1_valid;
  logic [1:0] s1_op;
  logic       s1_in_range;
  logic       s1_adv;

  logic [7:0] pend_byte;
  logic [7:0] pend_byte_next;
  logic [2:0] pend_count;
  logic [2:0] pend_count_next;

  logic [CODE_W-1:0] masked;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  shift;
  logic [WIN_W-1:0]  win;
  logic              enc_go;
  logic              flush_go;
  logic [1:0]        push_n;
  pack_t             push0;
  pack_t             push1;

  // Queue: four bytes, entry while at least two are free
  localparam int QD = 4;
  pack_t      fifo [QD];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] fcount;
  logic       pop;

  assign s1_adv     = s1_valid && (fcount <= 3'(QD - 2));
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= item.operation;
      s1_in_range <= in_range;
    end
  end

  // Code bits land just below the pending ones in a 24-bit window;
  // the top one or two bytes of the window are complete when the sum reaches 8 or 16.
  assign masked = rd_entry.code & ~({CODE_W{1'b1}} << rd_entry.length);
  assign total  = LEN_W'(pend_count) + rd_entry.length;
  assign shift  = LEN_W'(WIN_W) - LEN_W'(pend_count) - rd_entry.length;
  assign win    = {pend_byte, {CODE_W{1'b0}}} | ({8'b0, masked} << shift);

  assign enc_go   = s1_adv && (s1_op == OP_ENCODE) && s1_in_range;
  assign flush_go = s1_adv && (s1_op == OP_FLUSH) && (pend_count != 3'd0);

  always_comb begin
    push_n          = 2'd0;
    push0           = '{out_byte: win[WIN_W-1 -: 8], last: 1'b0};
    push1           = '{out_byte: win[WIN_W-9 -: 8], last: 1'b1};
    pend_byte_next  = pend_byte;
    pend_count_next = pend_count;
    if (enc_go) begin
      push_n          = total[4:3];
      pend_count_next = total[2:0];
      unique case (total[4:3])
        2'd0: pend_byte_next = win[WIN_W-1 -: 8];
        2'd1: begin
          pend_byte_next = win[WIN_W-9 -: 8];
          push0.last     = 1'b1;
        end
        default: pend_byte_next = win[7:0];
      endcase
    end else if (flush_go) begin
      push_n          = 2'd1;
      push0           = '{out_byte: pend_byte, last: 1'b1};
      pend_byte_next  = 8'd0;
      pend_count_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_byte  <= 8'd0;
      pend_count <= 3'd0;
    end else begin
      pend_byte  <= pend_byte_next;
      pend_count <= pend_count_next;
    end
  end

  // ---------------------------------------------------------------- output queue
  assign pack_valid = (fcount != 3'd0);
  assign pack       = fifo[rptr];
  assign pop        = pack_valid && pack_ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wptr] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo[wptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= 2'd0;
      rptr   <= 2'd0;
      fcount <= 3'd0;
    end else begin
      wptr   <= wptr + push_n;
      rptr   <= rptr + 2'(pop);
      fcount <= fcount + 3'(push_n) - 3'(pop);
    end
  end

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= 3'(QD))
    else $error("byte queue overfilled");

  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fcount == $past(fcount) + 3'($past(push_n)) - 3'($past(pop)))
    else $error("byte queue count out of step with pushes and pops");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (s1_op == OP_FLUSH)) |=> (pend_count == 3'd0))
    else $error("pending bits survive a flush");

endmodule

// ===== hw/rtl/hcbp_ram.sv =====
// Generic single-port RAM with registered read.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
